/* rtl/mte_pkg.sv */
`timescale 1ns / 1ps
package mte_pkg;

    localparam logic [2:0] MODE_MAP    = 3'd0;
    localparam logic [2:0] MODE_ARRAY  = 3'd1;
    localparam logic [2:0] MODE_STRHDR = 3'd2;
    localparam logic [2:0] MODE_STRBYT = 3'd3;
    localparam logic [2:0] MODE_NIL    = 3'd4;
    localparam logic [2:0] MODE_BOOL   = 3'd5;
    localparam logic [2:0] MODE_DOUBLE = 3'd6;
    localparam logic [2:0] MODE_INT    = 3'd7;

    localparam logic [7:0] FIXMAP   = 8'h80;
    localparam logic [7:0] FIXARRAY = 8'h90;
    localparam logic [7:0] FIXSTR   = 8'ha0;
    localparam logic [7:0] MAP16    = 8'hde;
    localparam logic [7:0] MAP32    = 8'hdf;
    localparam logic [7:0] ARRAY16  = 8'hdc;
    localparam logic [7:0] ARRAY32  = 8'hdd;
    localparam logic [7:0] STR8     = 8'hd9;
    localparam logic [7:0] STR16    = 8'hda;
    localparam logic [7:0] STR32    = 8'hdb;
    localparam logic [7:0] FLOAT64  = 8'hcb;
    localparam logic [7:0] INT64    = 8'hd3;
    localparam logic [7:0] INT32    = 8'hd2;
    localparam logic [7:0] NIL      = 8'hc0;
    localparam logic [7:0] FALSE_B  = 8'hc2;
    localparam logic [7:0] TRUE_B   = 8'hc3;

    localparam logic [2:0] REG_WIDE_INTEGERS = 3'd0;

    // one classified token: lead byte, then tail_len bytes taken MSB first from tail
    typedef struct packed {
        logic [7:0]  head;
        logic [3:0]  tail_len;
        logic [63:0] tail;
    } t_tok;

endpackage

/* rtl/mte_front.sv */
`timescale 1ns / 1ps
module mte_front
    import mte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_count,
    input  logic [63:0] i_payload,
    input  logic        i_truth,
    input  logic [7:0]  i_text_byte,
    input  logic        i_wide,
    output logic        o_valid,
    output t_tok        o_tok,
    input  logic        i_take
);

    t_tok       w_tok;
    t_tok       r_q [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;
    logic       w_lt16, w_lt32, w_lt256, w_lt64k;
    logic [31:0] w_sat;

    always_comb begin
        w_lt16  = (i_count[31:4] == '0);
        w_lt32  = (i_count[31:5] == '0);
        w_lt256 = (i_count[31:8] == '0);
        w_lt64k = (i_count[31:16] == '0);
    end

    // clamp to int32 range
    always_comb begin
        if (!i_payload[63] && (i_payload[62:31] != '0)) begin
            w_sat = 32'h7fff_ffff;
        end else if (i_payload[63] && (i_payload[62:31] != '1)) begin
            w_sat = 32'h8000_0000;
        end else begin
            w_sat = i_payload[31:0];
        end
    end

    always_comb begin
        w_tok = '{head: NIL, tail_len: 4'd0, tail: 64'd0};
        unique case (i_mode)
            MODE_MAP: begin
                if (w_lt32) begin
                    w_tok.head = FIXMAP | {3'b000, i_count[4:0]};
                end else if (w_lt64k) begin
                    w_tok = '{head: MAP16, tail_len: 4'd2, tail: {i_count[15:0], 48'd0}};
                end else begin
                    w_tok = '{head: MAP32, tail_len: 4'd4, tail: {i_count, 32'd0}};
                end
            end
            MODE_ARRAY: begin
                if (w_lt16) begin
                    w_tok.head = FIXARRAY | {4'b0000, i_count[3:0]};
                end else if (w_lt64k) begin
                    w_tok = '{head: ARRAY16, tail_len: 4'd2, tail: {i_count[15:0], 48'd0}};
                end else begin
                    w_tok = '{head: ARRAY32, tail_len: 4'd4, tail: {i_count, 32'd0}};
                end
            end
            MODE_STRHDR: begin
                if (w_lt32) begin
                    w_tok.head = FIXSTR | {3'b000, i_count[4:0]};
                end else if (w_lt256) begin
                    w_tok = '{head: STR8, tail_len: 4'd1, tail: {i_count[7:0], 56'd0}};
                end else if (w_lt64k) begin
                    w_tok = '{head: STR16, tail_len: 4'd2, tail: {i_count[15:0], 48'd0}};
                end else begin
                    w_tok = '{head: STR32, tail_len: 4'd4, tail: {i_count, 32'd0}};
                end
            end
            MODE_STRBYT: w_tok.head = i_text_byte;
            MODE_NIL:    w_tok.head = NIL;
            MODE_BOOL:   w_tok.head = i_truth ? TRUE_B : FALSE_B;
            MODE_DOUBLE: w_tok = '{head: FLOAT64, tail_len: 4'd8, tail: i_payload};
            MODE_INT: begin
                if (i_wide) begin
                    w_tok = '{head: INT64, tail_len: 4'd8, tail: i_payload};
                end else begin
                    w_tok = '{head: INT32, tail_len: 4'd4, tail: {w_sat, 32'd0}};
                end
            end
            default: w_tok.head = NIL;
        endcase
    end

    // two-entry token queue toward the back end
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_tok   = r_q[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_comb begin
        n_wptr = w_push ? ~r_wptr : r_wptr;
        n_rptr = w_pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_tok;
        end
    end

endmodule

/* rtl/mte_back.sv */
`timescale 1ns / 1ps
module mte_back
    import mte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_tok       i_tok,
    output logic       o_take,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic        r_busy;
    logic [3:0]  r_rem;
    logic [63:0] r_data;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        w_adv;

    // output register free or being drained this cycle
    assign w_adv  = !r_out_valid || pop;
    assign o_take = w_adv && !r_busy && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            if (r_busy) begin
                r_busy      <= (r_rem != 4'd1);
                r_out_valid <= 1'b1;
            end else begin
                r_busy      <= i_valid && (i_tok.tail_len != 4'd0);
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_busy) begin
                r_out_byte <= r_data[63:56];
                r_out_last <= (r_rem == 4'd1);
                r_data     <= {r_data[55:0], 8'd0};
                r_rem      <= r_rem - 4'd1;
            end else begin
                r_out_byte <= i_tok.head;
                r_out_last <= (i_tok.tail_len == 4'd0);
                r_data     <= i_tok.tail;
                r_rem      <= i_tok.tail_len;
            end
        end
    end

    assign empty      = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

/* rtl/messagepack_token_encoder.sv */
`timescale 1ns / 1ps
// Channel    Handshake          Payload
// tokens in  push / full        i_mode, i_count, i_payload, i_truth, i_text_byte
// bytes out  empty / pop        o_out_byte, o_last
// config     APB psel/penable   paddr, pwdata, prdata (wide_integers at 0x0)
//
// A token of N bytes leaves one byte per cycle while pop keeps the output register
// drained, so string content bytes stream at one item per cycle while pop keeps up.
// A token passes through the two-entry token queue before it reaches the output register.
// A two-entry token queue sits between the classifier and the byte sequencer:
// while a result waits, two more tokens are taken in before full rises.
// Reset (synchronous, active low) empties both sides and sets wide_integers to 1.
module messagepack_token_encoder
    import mte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_count,
    input  logic [63:0] i_payload,
    input  logic        i_truth,
    input  logic [7:0]  i_text_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic r_wide;
    logic w_valid;
    logic w_take;
    t_tok w_tok;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_WIDE_INTEGERS) ? {31'd0, r_wide} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b1;
        end else if (psel && penable && pwrite && pready && (paddr == REG_WIDE_INTEGERS)) begin
            r_wide <= pwdata[0];
        end
    end

    mte_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_mode      (i_mode),
        .i_count     (i_count),
        .i_payload   (i_payload),
        .i_truth     (i_truth),
        .i_text_byte (i_text_byte),
        .i_wide      (r_wide),
        .o_valid     (w_valid),
        .o_tok       (w_tok),
        .i_take      (w_take)
    );

    mte_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_tok      (w_tok),
        .o_take     (w_take),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule
